/* hdl/value_table_match_count_replace_remove_defines.svh */
// assertion helpers for the value table block
`ifndef VALUE_TABLE_MATCH_COUNT_REPLACE_REMOVE_DEFINES_SVH
`define VALUE_TABLE_MATCH_COUNT_REPLACE_REMOVE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define VTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define VTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/vtm_pkg.sv */
`default_nettype none

package vtm_pkg;

	// default table size
	localparam int TABLE_DEPTH_DEF = 32;

	// field widths
	localparam int ACT_W = 3;
	localparam int WORD_W = 32;
	localparam int IDX_W = 5;
	localparam int CNT_OUT_W = 6;
	localparam int STAT_W = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_COUNT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic report;
	} vtm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic go_scan;
		logic scan_last;
	} vtm_stat_t;

endpackage

`default_nettype wire

/* hdl/vtm_ram.sv */
`default_nettype none

module vtm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/vtm_ctrl.sv */
`default_nettype none

module vtm_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire vtm_pkg::vtm_stat_t stat,
	output vtm_pkg::vtm_cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_TAIL = 2'd2;
	localparam logic [1:0] S_REPORT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic done_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = stat.go_scan ? S_SCAN : S_REPORT;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_TAIL;
				end
			end
			S_TAIL: begin
				state_nxt = S_REPORT;
			end
			S_REPORT: begin
				cmd.report = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q <= cmd.report;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

/* hdl/vtm_dp.sv */
`default_nettype none

module vtm_dp #(
	parameter int TABLE_DEPTH = vtm_pkg::TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire vtm_pkg::vtm_cmd_t cmd,
	output vtm_pkg::vtm_stat_t stat,
	input wire logic [vtm_pkg::ACT_W-1:0] action,
	input wire logic signed [vtm_pkg::WORD_W-1:0] key_value,
	input wire logic signed [vtm_pkg::WORD_W-1:0] new_value,
	input wire logic [vtm_pkg::IDX_W-1:0] read_index,
	output logic [vtm_pkg::CNT_OUT_W-1:0] match_count,
	output logic signed [vtm_pkg::WORD_W-1:0] read_value,
	output logic [vtm_pkg::CNT_OUT_W-1:0] table_length,
	output logic [vtm_pkg::STAT_W-1:0] status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > vtm_pkg::IDX_W) ? CW : vtm_pkg::IDX_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// request registers
	logic [vtm_pkg::ACT_W-1:0] act_q;
	logic [vtm_pkg::WORD_W-1:0] key_q;
	logic [vtm_pkg::WORD_W-1:0] new_q;
	logic range_ok_q;

	// table length and walk state
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] match_q;
	logic [vtm_pkg::WORD_W-1:0] value_q;

	// compare stage, lined up with the ram read data
	logic valid_s1;
	logic [AW-1:0] addr_s1;

	// result registers
	logic [vtm_pkg::CNT_OUT_W-1:0] match_count_q;
	logic [vtm_pkg::WORD_W-1:0] read_value_q;
	logic [vtm_pkg::CNT_OUT_W-1:0] table_length_q;
	logic [vtm_pkg::STAT_W-1:0] status_q;

	// ram ports
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [vtm_pkg::WORD_W-1:0] mem_wdata;
	logic [vtm_pkg::WORD_W-1:0] mem_rdata;

	logic in_range;
	logic is_search;
	logic hit;
	logic not_full;

	vtm_ram #(
		.WIDTH(vtm_pkg::WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(cmd.scan),
		.raddr(ptr_q),
		.rdata(mem_rdata)
	);

	// decode of the incoming request
	always_comb begin
		in_range = (XW'(read_index) < XW'(count_q));
		is_search = (action == vtm_pkg::ACT_COUNT) || (action == vtm_pkg::ACT_REPLACE) ||
			(action == vtm_pkg::ACT_REMOVE);
		stat.go_scan = (is_search && (count_q != '0)) ||
			((action == vtm_pkg::ACT_READ) && in_range);
		stat.scan_last = (act_q == vtm_pkg::ACT_READ) || (ptr_q == AW'(count_q - 1'b1));
	end

	assign hit = (mem_rdata == key_q);
	assign not_full = (count_q < DEPTH_C);

	// ram write: replace in place, compacting copy, or append at the end
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = new_q;
		if (valid_s1) begin
			if ((act_q == vtm_pkg::ACT_REPLACE) && hit) begin
				mem_we = 1'b1;
			end else if ((act_q == vtm_pkg::ACT_REMOVE) && !hit) begin
				mem_we = 1'b1;
				mem_waddr = AW'(wr_q);
				mem_wdata = mem_rdata;
			end
		end else if (cmd.report && (act_q == vtm_pkg::ACT_APPEND) && not_full) begin
			mem_we = 1'b1;
			mem_waddr = AW'(count_q);
			mem_wdata = key_q;
		end
	end

	// request capture and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			key_q <= key_value;
			new_q <= new_value;
			range_ok_q <= in_range;
			ptr_q <= (action == vtm_pkg::ACT_READ) ? AW'(read_index) : '0;
			wr_q <= '0;
			match_q <= '0;
			value_q <= '0;
		end else begin
			if (cmd.scan) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (valid_s1) begin
				if ((act_q != vtm_pkg::ACT_READ) && hit) begin
					match_q <= match_q + 1'b1;
				end
				if ((act_q == vtm_pkg::ACT_REMOVE) && !hit) begin
					wr_q <= wr_q + 1'b1;
				end
				if (act_q == vtm_pkg::ACT_READ) begin
					value_q <= mem_rdata;
				end
			end
		end
		addr_s1 <= ptr_q;
	end

	// compare stage valid and table length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			valid_s1 <= cmd.scan;
			if (cmd.report) begin
				if ((act_q == vtm_pkg::ACT_APPEND) && not_full) begin
					count_q <= count_q + 1'b1;
				end else if (act_q == vtm_pkg::ACT_REMOVE) begin
					count_q <= wr_q;
				end
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			match_count_q <= vtm_pkg::CNT_OUT_W'(match_q);
			read_value_q <= '0;
			table_length_q <= vtm_pkg::CNT_OUT_W'(count_q);
			status_q <= vtm_pkg::ST_OK;
			case (act_q)
				vtm_pkg::ACT_APPEND: begin
					if (not_full) begin
						table_length_q <= vtm_pkg::CNT_OUT_W'(count_q + 1'b1);
					end else begin
						status_q <= vtm_pkg::ST_FULL;
					end
				end
				vtm_pkg::ACT_REMOVE: begin
					table_length_q <= vtm_pkg::CNT_OUT_W'(wr_q);
				end
				vtm_pkg::ACT_READ: begin
					if (range_ok_q) begin
						read_value_q <= value_q;
					end else begin
						status_q <= vtm_pkg::ST_RANGE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign match_count = match_count_q;
	assign read_value = read_value_q;
	assign table_length = table_length_q;
	assign status = status_q;

endmodule

`default_nettype wire

/* hdl/value_table_match_count_replace_remove.sv */
// Ordered table of signed 32-bit words with search, replace and compacting remove.
// Request side: drive action, key_value, new_value and read_index with start high;
// the word is taken at a clock edge where start is high and busy is low. busy stays
// high until the request has been answered.
// Result side: done is high for exactly one cycle and match_count, read_value,
// table_length and status are valid in that cycle. The receiver cannot stall, so
// the result must be taken when done is seen.
// Path from accept to done: append, empty-table searches, unknown actions and
// out-of-range reads go from idle straight to report; a good read, count, replace
// and remove pass through scan and tail first. The walk reads one entry per cycle
// through the single read port of the table ram and one comparator. A new request
// can be taken in the cycle done is high.
// Reset clears the length to zero and returns the controller to idle; the table
// ram is not cleared, entries are only read after being written.
`default_nettype none
`include "value_table_match_count_replace_remove_defines.svh"

module value_table_match_count_replace_remove #(
	parameter int TABLE_DEPTH = vtm_pkg::TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [vtm_pkg::ACT_W-1:0] action,
	input wire logic signed [vtm_pkg::WORD_W-1:0] key_value,
	input wire logic signed [vtm_pkg::WORD_W-1:0] new_value,
	input wire logic [vtm_pkg::IDX_W-1:0] read_index,
	output logic done,
	output logic [vtm_pkg::CNT_OUT_W-1:0] match_count,
	output logic signed [vtm_pkg::WORD_W-1:0] read_value,
	output logic [vtm_pkg::CNT_OUT_W-1:0] table_length,
	output logic [vtm_pkg::STAT_W-1:0] status
);

	vtm_pkg::vtm_cmd_t cmd;
	vtm_pkg::vtm_stat_t stat;

	// sequencer
	vtm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	// table, walk registers and result word
	vtm_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.action(action),
		.key_value(key_value),
		.new_value(new_value),
		.read_index(read_index),
		.match_count(match_count),
		.read_value(read_value),
		.table_length(table_length),
		.status(status)
	);

	// checks
	`VTM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy low after accept")
	`VTM_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "done held for two cycles")
	`VTM_ASSERT_NOW(a_full_no_match, clk, arst_n, done && (status == vtm_pkg::ST_FULL), (match_count == '0) && (read_value == '0), "full status with nonzero fields")
	`VTM_ASSERT_NOW(a_range_zero, clk, arst_n, done && (status == vtm_pkg::ST_RANGE), (read_value == '0) && (match_count == '0), "range status with nonzero fields")

endmodule

`default_nettype wire

/* tb/vtm_table_checker.sv */
`timescale 1ns / 100ps

module vtm_table_checker
	import vtm_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [ACT_W-1:0] action,
	input wire logic signed [WORD_W-1:0] key_value,
	input wire logic signed [WORD_W-1:0] new_value,
	input wire logic [IDX_W-1:0] read_index,
	input wire logic done,
	input wire logic [CNT_OUT_W-1:0] match_count,
	input wire logic signed [WORD_W-1:0] read_value,
	input wire logic [CNT_OUT_W-1:0] table_length,
	input wire logic [STAT_W-1:0] status,
	output int fail_count,
	output int words_pending
);

	// one answer word as the block reports it
	typedef struct {
		logic [CNT_OUT_W-1:0] hit_count;
		logic signed [WORD_W-1:0] value;
		logic [CNT_OUT_W-1:0] length;
		logic [STAT_W-1:0] stat;
	} answer_t;

	// mirror of the table contents and its fill level
	logic signed [WORD_W-1:0] table_copy [DEPTH];
	int table_len = 0;
	int errs = 0;
	answer_t expected_answers [$];

	// apply one request to the mirror and work out its answer
	task apply_request(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] key,
			input logic signed [WORD_W-1:0] repl, input logic [IDX_W-1:0] idx,
			output answer_t ans);
		int hits;
		int wr;
		hits = 0;
		wr = 0;
		ans.value = '0;
		ans.stat = ST_OK;
		case (act)
			ACT_APPEND: begin
				if (table_len < DEPTH) begin
					table_copy[table_len] = key;
					table_len++;
				end else begin
					ans.stat = ST_FULL;
				end
			end
			ACT_COUNT: begin
				for (int i = 0; i < table_len; i++)
					if (table_copy[i] == key) hits++;
			end
			ACT_REPLACE: begin
				for (int i = 0; i < table_len; i++) begin
					if (table_copy[i] == key) begin
						table_copy[i] = repl;
						hits++;
					end
				end
			end
			ACT_REMOVE: begin
				// survivors slide down in order
				for (int rd = 0; rd < table_len; rd++) begin
					if (table_copy[rd] != key) begin
						table_copy[wr] = table_copy[rd];
						wr++;
					end
				end
				hits = table_len - wr;
				table_len = wr;
			end
			ACT_READ: begin
				if (idx < table_len) ans.value = table_copy[idx];
				else ans.stat = ST_RANGE;
			end
			default: begin
			end
		endcase
		ans.hit_count = hits[CNT_OUT_W-1:0];
		ans.length = table_len[CNT_OUT_W-1:0];
	endtask

	// report a field that differs
	task check_field(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errs++;
		end
	endtask

	// watch both channels, compare answers in order
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		answer_t fresh;
		if (!arst_n) begin
			table_len = 0;
			expected_answers.delete();
			words_pending <= 0;
		end else begin
			if (done) begin
				if (expected_answers.size() == 0) begin
					$display("%0t ns: answer with none expected, matches %0h value %0h",
						$time, match_count, read_value);
					errs++;
				end else begin
					want = expected_answers.pop_front();
					check_field("match_count", WORD_W'(want.hit_count), WORD_W'(match_count));
					check_field("read_value", want.value, read_value);
					check_field("table_length", WORD_W'(want.length), WORD_W'(table_length));
					check_field("status", WORD_W'(want.stat), WORD_W'(status));
				end
			end
			if (start && !busy) begin
				apply_request(action, key_value, new_value, read_index, fresh);
				expected_answers.push_back(fresh);
			end
			words_pending <= expected_answers.size();
		end
		fail_count <= errs;
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import vtm_pkg::*;

	// action codes the block ignores
	localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;
	localparam int RANDOM_WORDS = 2000;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ACT_W-1:0] action = ACT_APPEND;
	logic signed [WORD_W-1:0] key_value = '0;
	logic signed [WORD_W-1:0] new_value = '0;
	logic [IDX_W-1:0] read_index = '0;
	logic done;
	logic [CNT_OUT_W-1:0] match_count;
	logic signed [WORD_W-1:0] read_value;
	logic [CNT_OUT_W-1:0] table_length;
	logic [STAT_W-1:0] status;
	int fail_count;
	int words_pending;
	int stall_cycles = 0;
	bit no_idle = 1'b0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	value_table_match_count_replace_remove dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key_value(key_value),
		.new_value(new_value),
		.read_index(read_index),
		.done(done),
		.match_count(match_count),
		.read_value(read_value),
		.table_length(table_length),
		.status(status)
	);

	vtm_table_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.key_value(key_value),
		.new_value(new_value),
		.read_index(read_index),
		.done(done),
		.match_count(match_count),
		.read_value(read_value),
		.table_length(table_length),
		.status(status),
		.fail_count(fail_count),
		.words_pending(words_pending)
	);

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly words from a small pool so searches hit, sometimes anything
	function automatic logic signed [WORD_W-1:0] draw_word();
		if ($urandom_range(0, 3) == 0) return $urandom;
		case ($urandom_range(0, 7))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5: return 32'sh5a5a5a5a;
			6: return 32'sha5a5a5a5;
			default: return 32'sd42;
		endcase
	endfunction

	// present one request word and hold it until taken, then maybe idle
	task automatic send_word(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] key,
			input logic signed [WORD_W-1:0] repl, input logic [IDX_W-1:0] idx);
		int gap;
		action <= act;
		key_value <= key;
		new_value <= repl;
		read_index <= idx;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every answer is back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	initial begin
		int mode;
		int app_w;
		int rem_w;
		int r;
		logic [ACT_W-1:0] act;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every search, a read out of range, ignored actions
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd0);
		send_word(ACT_COUNT, 32'sd0, 32'sd0, 5'd0);
		send_word(ACT_REPLACE, 32'sd0, WORD_MAX, 5'd0);
		send_word(ACT_REMOVE, 32'sd0, 32'sd0, 5'd0);
		send_word(ACT_RSVD5, WORD_MAX, WORD_MIN, 5'd31);
		send_word(ACT_RSVD6, WORD_MIN, WORD_MAX, 5'd0);
		send_word(ACT_RSVD7, -32'sd1, -32'sd1, 5'd31);

		// extremes of the word, with a repeated key
		send_word(ACT_APPEND, WORD_MAX, 32'sd0, 5'd0);
		send_word(ACT_APPEND, WORD_MIN, 32'sd0, 5'd0);
		send_word(ACT_APPEND, 32'sd0, 32'sd0, 5'd0);
		send_word(ACT_APPEND, -32'sd1, 32'sd0, 5'd0);
		send_word(ACT_APPEND, WORD_MIN, 32'sd0, 5'd0);
		send_word(ACT_COUNT, WORD_MIN, 32'sd0, 5'd0);
		send_word(ACT_REPLACE, WORD_MIN, WORD_MAX, 5'd0);
		send_word(ACT_COUNT, WORD_MAX, 32'sd0, 5'd0);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd4);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd3);

		// remove with matches next to each other, then reads around the new end
		send_word(ACT_REMOVE, WORD_MAX, 32'sd0, 5'd0);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd0);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd1);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd2);
		send_word(ACT_READ, 32'sd0, 32'sd0, 5'd31);

		// random part: fill-heavy, mixed and drain-heavy stretches
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0) begin
				mode = (i / 100) % 3;
				no_idle = ((i / 100) % 4 == 3);
			end
			if (i % 500 == 250) wait_drained();
			app_w = (mode == 0) ? 55 : (mode == 1) ? 30 : 15;
			rem_w = (mode == 0) ? 5 : (mode == 1) ? 15 : 30;
			r = $urandom_range(0, 99);
			if (r < app_w) act = ACT_APPEND;
			else if (r < app_w + rem_w) act = ACT_REMOVE;
			else if (r < app_w + rem_w + 15) act = ACT_COUNT;
			else if (r < app_w + rem_w + 30) act = ACT_REPLACE;
			else if (r < 95) act = ACT_READ;
			else act = ACT_W'($urandom_range(ACT_RSVD5, ACT_RSVD7));
			send_word(act, draw_word(), draw_word(), IDX_W'($urandom_range(0, 31)));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
